### sv/lwma_pkg.sv
// ----------------------------------------------------------------------------
// lwma_pkg: shared types and constants of the weighted moving average
// Widths, sequencer states, the lane control word and the total weight
// function that gives the divisor for a window length.
// ----------------------------------------------------------------------------
`default_nettype none

package lwma_pkg;

   localparam int SAMPLE_W  = 16;
   localparam int CHANNELS  = 4;
   localparam int WORD_W    = SAMPLE_W * CHANNELS;
   localparam int WIN_MAX   = 32;
   localparam int PTR_W     = 5;
   localparam int LEN_W     = 6;
   localparam int SUM_W     = 22;
   localparam int WSUM_W    = 27;
   localparam int XS_W      = SAMPLE_W + 5;
   localparam int TOT_W     = 10;
   localparam int DEN_W     = TOT_W + SAMPLE_W - 1;
   localparam int SEEN_W    = 16;
   localparam int CNT_W     = 4;
   localparam int MUL_STEPS = LEN_W;
   localparam int DIV_STEPS = SAMPLE_W;

   localparam logic [SEEN_W-1:0] SEEN_MAX = {SEEN_W{1'b1}};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_MULT,
      ST_LOAD,
      ST_DIV,
      ST_DONE
   } state_type;

   // Control word from the sequencer to each channel lane.
   typedef struct packed {
      logic             clear;
      logic             load;
      logic             update;
      logic             drop_valid;
      logic             mul_step;
      logic             mul_bit;
      logic             div_load;
      logic             div_step;
      logic [TOT_W-1:0] total;
   } lane_ctrl_type;

   // Sum of the weights 1..len, that is len*(len+1)/2.
   function automatic logic [TOT_W-1:0] total_weight(input logic [LEN_W-1:0] len);
      logic [TOT_W:0] prod;
      prod = (TOT_W+1)'(len) * ((TOT_W+1)'(len) + (TOT_W+1)'(1));
      return prod[TOT_W:1];
   endfunction

endpackage

`default_nettype wire

### sv/lwma_store.sv
// ----------------------------------------------------------------------------
// lwma_store: sample ring buffer
// One word of four samples per entry, one write port and one registered
// read port. The read returns the entry as it was before a same-cycle write.
// ----------------------------------------------------------------------------
`default_nettype none

module lwma_store (
   input  wire                              clock,
   input  wire                              wr_en,
   input  wire  [lwma_pkg::PTR_W-1:0]       wr_addr,
   input  wire  [lwma_pkg::WORD_W-1:0]      wr_data,
   input  wire  [lwma_pkg::PTR_W-1:0]       rd_addr,
   output logic [lwma_pkg::WORD_W-1:0]      rd_data
);

   logic [lwma_pkg::WORD_W-1:0] mem_ff [lwma_pkg::WIN_MAX];
   logic [lwma_pkg::WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### sv/lwma_lane.sv
// ----------------------------------------------------------------------------
// lwma_lane: one channel of the weighted moving average
// Keeps the plain and weighted window sums, multiplies the new sample by
// the window length one bit per cycle and divides by the total weight with
// a restoring divider that yields one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lwma_lane (
   input  wire                                  clock,
   input  lwma_pkg::lane_ctrl_type              ctrl,
   input  wire  signed [lwma_pkg::SAMPLE_W-1:0] sample,
   input  wire  signed [lwma_pkg::SAMPLE_W-1:0] drop,
   output logic signed [lwma_pkg::SAMPLE_W-1:0] avg
);

   logic signed [lwma_pkg::SUM_W-1:0]    sum_ff;
   logic signed [lwma_pkg::WSUM_W-1:0]   wsum_ff;
   logic signed [lwma_pkg::XS_W-1:0]     xs_ff;
   logic        [lwma_pkg::WSUM_W-1:0]   rem_ff;
   logic        [lwma_pkg::DEN_W-1:0]    den_ff;
   logic        [lwma_pkg::SAMPLE_W-1:0] quo_ff;
   logic                                 neg_ff;

   logic signed [lwma_pkg::SAMPLE_W-1:0] drop_eff;
   logic        [lwma_pkg::WSUM_W-1:0]   den_ext;
   logic                                 fits;

   assign drop_eff = ctrl.drop_valid ? drop : '0;
   assign den_ext  = lwma_pkg::WSUM_W'(den_ff);
   assign fits     = rem_ff >= den_ext;

   // The weighted sum drops the old plain sum and gains len times the new
   // sample; samples not yet in the window count as zero.
   always_ff @(posedge clock) begin
      if (ctrl.clear) begin
         sum_ff  <= '0;
         wsum_ff <= '0;
      end else if (ctrl.update) begin
         sum_ff  <= sum_ff + lwma_pkg::SUM_W'(xs_ff) - lwma_pkg::SUM_W'(drop_eff);
         wsum_ff <= wsum_ff - lwma_pkg::WSUM_W'(sum_ff);
      end else if (ctrl.mul_step && ctrl.mul_bit) begin
         wsum_ff <= wsum_ff + lwma_pkg::WSUM_W'(xs_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         xs_ff <= lwma_pkg::XS_W'(sample);
      end else if (ctrl.mul_step) begin
         xs_ff <= xs_ff <<< 1;
      end
   end

   // The quotient magnitude never exceeds 2**15, so the divisor starts at
   // total << 15 and sixteen steps suffice.
   always_ff @(posedge clock) begin
      if (ctrl.div_load) begin
         neg_ff <= wsum_ff[lwma_pkg::WSUM_W-1];
         rem_ff <= wsum_ff[lwma_pkg::WSUM_W-1] ? lwma_pkg::WSUM_W'(-wsum_ff)
                                               : lwma_pkg::WSUM_W'(wsum_ff);
         den_ff <= {ctrl.total, {(lwma_pkg::SAMPLE_W-1){1'b0}}};
         quo_ff <= '0;
      end else if (ctrl.div_step) begin
         if (fits) begin
            rem_ff <= rem_ff - den_ext;
         end
         quo_ff <= {quo_ff[lwma_pkg::SAMPLE_W-2:0], fits};
         den_ff <= den_ff >> 1;
      end
   end

   assign avg = neg_ff ? lwma_pkg::SAMPLE_W'(-quo_ff) : quo_ff;

endmodule

`default_nettype wire

### sv/linear_weighted_moving_average_x4.sv
// ----------------------------------------------------------------------------
// linear_weighted_moving_average_x4: four-channel weighted moving average
// Open, high, low and close samples pass through a ring buffer; each new word
// updates the per-channel window sums and, once the window is full, yields
// the weighted averages and the running sample number.
// ----------------------------------------------------------------------------
//   The req channel takes one word of four signed samples when req_valid is
//   high and req_stall is low. The rsp channel presents one result word per
//   input word once window_len words have arrived since reset or the last
//   window_len write; earlier words give no result.
//   csr_window_len sets the window length (0 counts as 1, above 32 as 32);
//   a write clears the window, the sample count and the sums.
//   Each word passes through one update step, six multiply steps, one
//   load step, sixteen divide steps and one step to hand the result
//   over; req_stall stays high meanwhile, so no new word is taken before
//   the last is through. The next word is accepted while a result waits
//   in the output register; a stalled rsp side holds the sequencer in
//   its done state only when a second result is ready. Synchronous reset
//   sets the window length to 1 and empties the block.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_weighted_moving_average_x4 (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  wire  signed [lwma_pkg::SAMPLE_W-1:0] req_open_val,
   input  wire  signed [lwma_pkg::SAMPLE_W-1:0] req_high_val,
   input  wire  signed [lwma_pkg::SAMPLE_W-1:0] req_low_val,
   input  wire  signed [lwma_pkg::SAMPLE_W-1:0] req_close_val,
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output logic signed [lwma_pkg::SAMPLE_W-1:0] rsp_avg_open,
   output logic signed [lwma_pkg::SAMPLE_W-1:0] rsp_avg_high,
   output logic signed [lwma_pkg::SAMPLE_W-1:0] rsp_avg_low,
   output logic signed [lwma_pkg::SAMPLE_W-1:0] rsp_avg_close,
   output logic        [lwma_pkg::SEEN_W-1:0]   rsp_sample_number,
   input  wire                                  csr_valid,
   output logic                                 csr_ready,
   input  wire         [lwma_pkg::LEN_W-1:0]    csr_window_len
);

   lwma_pkg::state_type state_ff, state_in;

   logic [lwma_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic [lwma_pkg::LEN_W-1:0]  len_ff;
   logic [lwma_pkg::LEN_W-1:0]  mul_len_ff;
   logic [lwma_pkg::PTR_W-1:0]  wp_ff;
   logic [lwma_pkg::SEEN_W-1:0] seen_ff;
   logic [lwma_pkg::SEEN_W-1:0] seen_in;
   logic [lwma_pkg::SEEN_W-1:0] num_ff;
   logic                        drop_valid_ff;
   logic                        result_ff;
   logic                        rsp_valid_ff;
   logic signed [lwma_pkg::SAMPLE_W-1:0] avg_ff [lwma_pkg::CHANNELS];
   logic [lwma_pkg::SEEN_W-1:0] rsp_num_ff;

   logic                        accept;
   logic                        csr_write;
   logic                        publish;
   logic [lwma_pkg::LEN_W-1:0]  csr_len;
   logic [lwma_pkg::PTR_W-1:0]  rd_addr;
   logic [lwma_pkg::WORD_W-1:0] wr_data;
   logic [lwma_pkg::WORD_W-1:0] rd_data;
   lwma_pkg::lane_ctrl_type     ctrl;

   logic signed [lwma_pkg::SAMPLE_W-1:0] samples [lwma_pkg::CHANNELS];
   logic signed [lwma_pkg::SAMPLE_W-1:0] avgs    [lwma_pkg::CHANNELS];

   assign req_stall = (state_ff != lwma_pkg::ST_IDLE);
   assign csr_ready = (state_ff == lwma_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      csr_len = csr_window_len;
      if (csr_window_len == '0) begin
         csr_len = lwma_pkg::LEN_W'(1);
      end else if (csr_window_len > lwma_pkg::LEN_W'(lwma_pkg::WIN_MAX)) begin
         csr_len = lwma_pkg::LEN_W'(lwma_pkg::WIN_MAX);
      end
   end

   assign seen_in = (seen_ff == lwma_pkg::SEEN_MAX) ? seen_ff
                                                    : seen_ff + lwma_pkg::SEEN_W'(1);

   // The sample leaving the window sits len entries behind the write pointer;
   // for a full-size window that is the slot being overwritten.
   assign rd_addr = wp_ff - len_ff[lwma_pkg::PTR_W-1:0];
   assign wr_data = {req_close_val, req_low_val, req_high_val, req_open_val};

   assign samples[0] = req_open_val;
   assign samples[1] = req_high_val;
   assign samples[2] = req_low_val;
   assign samples[3] = req_close_val;

   lwma_store u_store (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (wp_ff),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   for (genvar c = 0; c < lwma_pkg::CHANNELS; c++) begin : g_lane
      lwma_lane u_lane (
         .clock  (clock),
         .ctrl   (ctrl),
         .sample (samples[c]),
         .drop   (rd_data[c*lwma_pkg::SAMPLE_W +: lwma_pkg::SAMPLE_W]),
         .avg    (avgs[c])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lwma_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in         = state_ff;
      cnt_in           = cnt_ff;
      publish          = 1'b0;
      ctrl             = '0;
      ctrl.clear       = reset || csr_write;
      ctrl.load        = accept;
      ctrl.drop_valid  = drop_valid_ff;
      ctrl.mul_bit     = mul_len_ff[0];
      ctrl.total       = lwma_pkg::total_weight(len_ff);
      case (state_ff)
         lwma_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = lwma_pkg::ST_UPDATE;
            end
         end
         lwma_pkg::ST_UPDATE: begin
            ctrl.update = 1'b1;
            cnt_in      = '0;
            state_in    = lwma_pkg::ST_MULT;
         end
         lwma_pkg::ST_MULT: begin
            ctrl.mul_step = 1'b1;
            cnt_in        = cnt_ff + lwma_pkg::CNT_W'(1);
            if (cnt_ff == lwma_pkg::CNT_W'(lwma_pkg::MUL_STEPS - 1)) begin
               state_in = lwma_pkg::ST_LOAD;
            end
         end
         lwma_pkg::ST_LOAD: begin
            ctrl.div_load = 1'b1;
            cnt_in        = '0;
            state_in      = lwma_pkg::ST_DIV;
         end
         lwma_pkg::ST_DIV: begin
            ctrl.div_step = 1'b1;
            cnt_in        = cnt_ff + lwma_pkg::CNT_W'(1);
            if (cnt_ff == lwma_pkg::CNT_W'(lwma_pkg::DIV_STEPS - 1)) begin
               state_in = lwma_pkg::ST_DONE;
            end
         end
         lwma_pkg::ST_DONE: begin
            if (!result_ff) begin
               state_in = lwma_pkg::ST_IDLE;
            end else if (!rsp_valid_ff || !rsp_stall) begin
               publish  = 1'b1;
               state_in = lwma_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lwma_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= lwma_pkg::LEN_W'(1);
         wp_ff   <= '0;
         seen_ff <= '0;
      end else if (csr_write) begin
         len_ff  <= csr_len;
         wp_ff   <= '0;
         seen_ff <= '0;
      end else if (accept) begin
         wp_ff   <= wp_ff + lwma_pkg::PTR_W'(1);
         seen_ff <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         num_ff        <= seen_in;
         drop_valid_ff <= seen_ff >= lwma_pkg::SEEN_W'(len_ff);
         result_ff     <= seen_in >= lwma_pkg::SEEN_W'(len_ff);
         mul_len_ff    <= len_ff;
      end else if (state_ff == lwma_pkg::ST_MULT) begin
         mul_len_ff    <= mul_len_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (publish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (publish) begin
         for (int c = 0; c < lwma_pkg::CHANNELS; c++) begin
            avg_ff[c] <= avgs[c];
         end
         rsp_num_ff <= num_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_avg_open      = avg_ff[0];
   assign rsp_avg_high      = avg_ff[1];
   assign rsp_avg_low       = avg_ff[2];
   assign rsp_avg_close     = avg_ff[3];
   assign rsp_sample_number = rsp_num_ff;

endmodule

`default_nettype wire
